/* sv/hgcd_pkg.sv */
package hgcd_pkg;

  // datapath widths
  localparam int ANGLE_W      = 34;
  localparam int WRAP_W       = 36;
  localparam int MAG_W        = 32;
  localparam int TRIG_W       = 34;
  localparam int PROD_W       = 2 * TRIG_W;
  localparam int A_W          = 31;
  localparam int ROOT_W       = 31;
  localparam int SQ_W         = 62;
  localparam int VZ_W         = 36;
  localparam int C_W          = 32;
  localparam int RADIUS_W     = 24;
  localparam int DIST_W       = 34;
  localparam int LANES        = 4;
  localparam int CORDIC_STEPS = 32;
  localparam int SQRT_STEPS   = 31;

  // angles in degrees with 25 fraction bits
  localparam logic signed [WRAP_W-1:0] FULL_TURN_Q25    = 36'sd12079595520;
  localparam logic signed [WRAP_W-1:0] HALF_TURN_Q25    = 36'sd6039797760;
  localparam logic signed [WRAP_W-1:0] QUARTER_TURN_Q25 = 36'sd3019898880;

  // pi/180 scaled by 2^32
  localparam logic [26:0] DEG_TO_RAD_Q32 = 27'd74961321;

  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic [A_W-1:0]           ONE_Q30         = 31'd1073741824;
  localparam logic [C_W-1:0]           PI_Q30          = 32'd3373259426;
  localparam logic [VZ_W-1:0]          HALF_PI_Q30     = 36'd1686629713;
  localparam logic [DIST_W-1:0]        DIST_MAX_Q16    = 34'd13493037705;
  localparam logic [RADIUS_W-1:0]      RADIUS_RESET_Q8 = 24'd1630976;

  // arctan(2^-i) in radians, 30 fraction bits
  localparam logic [29:0] ATAN_Q30 [CORDIC_STEPS] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
    30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
    30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535, 30'd32767,
    30'd16383, 30'd8191, 30'd4095, 30'd2047, 30'd1023, 30'd511, 30'd255,
    30'd127, 30'd63, 30'd31, 30'd15, 30'd8, 30'd4, 30'd2, 30'd1, 30'd0
  };

  // round a product of two q30 values back to q30
  function automatic logic signed [TRIG_W-1:0] round_q30(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = (p + PROD_W'(64'sd536870912)) >>> 30;
    return t[TRIG_W-1:0];
  endfunction

endpackage

/* sv/hgcd_angle_prep.sv */
module hgcd_angle_prep (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       en_i,
  input  logic                                       valid_i,
  input  logic signed [hgcd_pkg::ANGLE_W-1:0]        angle_i [hgcd_pkg::LANES],
  output logic                                       valid_o,
  output logic signed [hgcd_pkg::TRIG_W-1:0]         z_o [hgcd_pkg::LANES],
  output logic [hgcd_pkg::LANES-1:0]                 flip_o
);

  logic                            valid_a_q;
  logic [hgcd_pkg::LANES-1:0]      neg_q;
  logic [hgcd_pkg::LANES-1:0]      flip_a_q;
  logic [hgcd_pkg::MAG_W-1:0]      mag_q [hgcd_pkg::LANES];
  logic                            valid_q;
  logic [hgcd_pkg::LANES-1:0]      flip_q;
  logic signed [hgcd_pkg::TRIG_W-1:0] z_q [hgcd_pkg::LANES];

  for (genvar l = 0; l < hgcd_pkg::LANES; l++) begin : g_lane
    logic signed [hgcd_pkg::WRAP_W-1:0] ext;
    logic signed [hgcd_pkg::WRAP_W-1:0] wrap;
    logic signed [hgcd_pkg::WRAP_W-1:0] fold;
    logic signed [hgcd_pkg::WRAP_W-1:0] absv;
    logic                               flip_d;
    logic [58:0]                        prod;
    logic [58:0]                        rnd;
    logic signed [hgcd_pkg::TRIG_W-1:0] zm;

    // reduce to one turn, then fold into the right half plane
    always_comb begin
      ext = hgcd_pkg::WRAP_W'(angle_i[l]);
      if (ext >= hgcd_pkg::HALF_TURN_Q25) begin
        wrap = ext - hgcd_pkg::FULL_TURN_Q25;
      end else if (ext < -hgcd_pkg::HALF_TURN_Q25) begin
        wrap = ext + hgcd_pkg::FULL_TURN_Q25;
      end else begin
        wrap = ext;
      end
      if (wrap > hgcd_pkg::QUARTER_TURN_Q25) begin
        fold   = hgcd_pkg::HALF_TURN_Q25 - wrap;
        flip_d = 1'b1;
      end else if (wrap < -hgcd_pkg::QUARTER_TURN_Q25) begin
        fold   = -hgcd_pkg::HALF_TURN_Q25 - wrap;
        flip_d = 1'b1;
      end else begin
        fold   = wrap;
        flip_d = 1'b0;
      end
      absv = fold[hgcd_pkg::WRAP_W-1] ? -fold : fold;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        mag_q[l]    <= absv[hgcd_pkg::MAG_W-1:0];
        neg_q[l]    <= fold[hgcd_pkg::WRAP_W-1];
        flip_a_q[l] <= flip_d;
      end
    end

    // degrees to radians with rounding
    always_comb begin
      prod = 59'(mag_q[l]) * 59'(hgcd_pkg::DEG_TO_RAD_Q32);
      rnd  = prod + 59'(64'd67108864);
      zm   = hgcd_pkg::TRIG_W'(rnd[58:27]);
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        z_q[l]    <= neg_q[l] ? -zm : zm;
        flip_q[l] <= flip_a_q[l];
      end
    end

    assign z_o[l] = z_q[l];
  end

  // valid bits follow the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_q   <= 1'b0;
    end else if (en_i) begin
      valid_a_q <= valid_i;
      valid_q   <= valid_a_q;
    end
  end

  assign valid_o = valid_q;
  assign flip_o  = flip_q;

endmodule

/* sv/hgcd_cordic_rot.sv */
module hgcd_cordic_rot (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic signed [hgcd_pkg::TRIG_W-1:0]  z_i [hgcd_pkg::LANES],
  input  logic [hgcd_pkg::LANES-1:0]          flip_i,
  output logic                                valid_o,
  output logic signed [hgcd_pkg::TRIG_W-1:0]  trig_o [hgcd_pkg::LANES]
);

  localparam int N = hgcd_pkg::CORDIC_STEPS;

  logic                       valid_q [N];
  logic [hgcd_pkg::LANES-1:0] flip_q  [N];

  // control travels beside the rotation stages
  for (genvar s = 0; s < N; s++) begin : g_ctl
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (en_i) begin
        valid_q[s] <= (s == 0) ? valid_i : valid_q[(s == 0) ? 0 : s-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        flip_q[s] <= (s == 0) ? flip_i : flip_q[(s == 0) ? 0 : s-1];
      end
    end
  end

  for (genvar l = 0; l < hgcd_pkg::LANES; l++) begin : g_lane
    logic signed [hgcd_pkg::TRIG_W-1:0] x_q [N];
    logic signed [hgcd_pkg::TRIG_W-1:0] y_q [N];
    logic signed [hgcd_pkg::TRIG_W-1:0] z_q [N];

    for (genvar s = 0; s < N; s++) begin : g_step
      logic signed [hgcd_pkg::TRIG_W-1:0] x_in, y_in, z_in;
      logic signed [hgcd_pkg::TRIG_W-1:0] x_d, y_d, z_d;
      logic signed [hgcd_pkg::TRIG_W-1:0] atan;

      if (s == 0) begin : g_first
        assign x_in = hgcd_pkg::CORDIC_GAIN_Q30;
        assign y_in = '0;
        assign z_in = z_i[l];
      end else begin : g_next
        assign x_in = x_q[s-1];
        assign y_in = y_q[s-1];
        assign z_in = z_q[s-1];
      end

      assign atan = $signed(hgcd_pkg::TRIG_W'(hgcd_pkg::ATAN_Q30[s]));

      // one micro-rotation towards zero residual angle
      always_comb begin
        if (!z_in[hgcd_pkg::TRIG_W-1]) begin
          x_d = x_in - (y_in >>> s);
          y_d = y_in + (x_in >>> s);
          z_d = z_in - atan;
        end else begin
          x_d = x_in + (y_in >>> s);
          y_d = y_in - (x_in >>> s);
          z_d = z_in + atan;
        end
      end

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          x_q[s] <= x_d;
          y_q[s] <= y_d;
          z_q[s] <= z_d;
        end
      end
    end

    // difference lanes give sine, latitude lanes give cosine
    if (l < 2) begin : g_sin
      assign trig_o[l] = y_q[N-1];
    end else begin : g_cos
      assign trig_o[l] = flip_q[N-1][l] ? -x_q[N-1] : x_q[N-1];
    end
  end

  assign valid_o = valid_q[N-1];

endmodule

/* sv/hgcd_haver.sv */
module hgcd_haver (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic signed [hgcd_pkg::TRIG_W-1:0]  trig_i [hgcd_pkg::LANES],
  output logic                                valid_o,
  output logic [hgcd_pkg::A_W-1:0]            a_o
);

  localparam int PW = hgcd_pkg::PROD_W;
  localparam int TW = hgcd_pkg::TRIG_W;

  logic [3:0]           valid_q;
  logic signed [PW-1:0] p_lat_q, p_cc_q, p_lon_q;
  logic signed [TW-1:0] r_lat_q, r_cc_q, r_lon_q;
  logic signed [TW-1:0] r_lat2_q;
  logic signed [PW-1:0] p_ab_q;
  logic [hgcd_pkg::A_W-1:0] a_q;
  logic signed [TW:0]   sum;

  // squares and the cosine product
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_lat_q <= PW'(trig_i[0]) * PW'(trig_i[0]);
      p_lon_q <= PW'(trig_i[1]) * PW'(trig_i[1]);
      p_cc_q  <= PW'(trig_i[2]) * PW'(trig_i[3]);
    end
  end

  // back to q30
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_lat_q <= hgcd_pkg::round_q30(p_lat_q);
      r_lon_q <= hgcd_pkg::round_q30(p_lon_q);
      r_cc_q  <= hgcd_pkg::round_q30(p_cc_q);
    end
  end

  // longitude term
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_ab_q   <= PW'(r_cc_q) * PW'(r_lon_q);
      r_lat2_q <= r_lat_q;
    end
  end

  // sum and clamp to the unit range
  always_comb begin
    sum = (TW+1)'(r_lat2_q) + (TW+1)'(hgcd_pkg::round_q30(p_ab_q));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (sum[TW]) begin
        a_q <= '0;
      end else if (sum > $signed((TW+1)'(hgcd_pkg::ONE_Q30))) begin
        a_q <= hgcd_pkg::ONE_Q30;
      end else begin
        a_q <= sum[hgcd_pkg::A_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[2:0], valid_i};
    end
  end

  assign valid_o = valid_q[3];
  assign a_o     = a_q;

endmodule

/* sv/hgcd_isqrt.sv */
module hgcd_isqrt (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic [hgcd_pkg::A_W-1:0]        a_i,
  output logic                            valid_o,
  output logic [hgcd_pkg::ROOT_W-1:0]     root_a_o,
  output logic [hgcd_pkg::ROOT_W-1:0]     root_b_o
);

  localparam int N  = hgcd_pkg::SQRT_STEPS;
  localparam int SW = hgcd_pkg::SQ_W;

  logic valid_q [N];
  logic [hgcd_pkg::ROOT_W-1:0] root [2];

  for (genvar s = 0; s < N; s++) begin : g_ctl
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (en_i) begin
        valid_q[s] <= (s == 0) ? valid_i : valid_q[(s == 0) ? 0 : s-1];
      end
    end
  end

  // lane 0 takes a, lane 1 takes one minus a, both scaled by 2^30
  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [SW-1:0] v_q   [N];
    logic [SW-1:0] res_q [N];
    logic [hgcd_pkg::A_W-1:0] arg;

    assign arg = (l == 0) ? a_i : (hgcd_pkg::ONE_Q30 - a_i);

    for (genvar s = 0; s < N; s++) begin : g_step
      localparam logic [SW-1:0] BIT = SW'(1) << (2 * (N - 1 - s));
      logic [SW-1:0] v_in, res_in, trial, v_d, res_d;

      if (s == 0) begin : g_first
        assign v_in   = SW'({arg, 30'd0});
        assign res_in = '0;
      end else begin : g_next
        assign v_in   = v_q[s-1];
        assign res_in = res_q[s-1];
      end

      // one result bit per stage
      always_comb begin
        trial = res_in + BIT;
        if (v_in >= trial) begin
          v_d   = v_in - trial;
          res_d = (res_in >> 1) + BIT;
        end else begin
          v_d   = v_in;
          res_d = res_in >> 1;
        end
      end

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          v_q[s]   <= v_d;
          res_q[s] <= res_d;
        end
      end
    end

    assign root[l] = res_q[N-1][hgcd_pkg::ROOT_W-1:0];
  end

  assign valid_o  = valid_q[N-1];
  assign root_a_o = root[0];
  assign root_b_o = root[1];

endmodule

/* sv/hgcd_cordic_vec.sv */
module hgcd_cordic_vec (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  logic [hgcd_pkg::ROOT_W-1:0]        x_i,
  input  logic [hgcd_pkg::ROOT_W-1:0]        y_i,
  output logic                               valid_o,
  output logic signed [hgcd_pkg::VZ_W-1:0]   z_o
);

  localparam int N  = hgcd_pkg::CORDIC_STEPS;
  localparam int TW = hgcd_pkg::TRIG_W;
  localparam int ZW = hgcd_pkg::VZ_W;

  logic                 valid_q [N];
  logic signed [TW-1:0] x_q [N];
  logic signed [TW-1:0] y_q [N];
  logic signed [ZW-1:0] z_q [N];

  for (genvar s = 0; s < N; s++) begin : g_step
    logic signed [TW-1:0] x_in, y_in, x_d, y_d;
    logic signed [ZW-1:0] z_in, z_d, atan;

    if (s == 0) begin : g_first
      assign x_in = $signed(TW'(x_i));
      assign y_in = $signed(TW'(y_i));
      assign z_in = '0;
    end else begin : g_next
      assign x_in = x_q[s-1];
      assign y_in = y_q[s-1];
      assign z_in = z_q[s-1];
    end

    assign atan = $signed(ZW'(hgcd_pkg::ATAN_Q30[s]));

    // drive y towards zero and total the angle
    always_comb begin
      if (!y_in[TW-1] && (y_in != '0)) begin
        x_d = x_in + (y_in >>> s);
        y_d = y_in - (x_in >>> s);
        z_d = z_in + atan;
      end else begin
        x_d = x_in - (y_in >>> s);
        y_d = y_in + (x_in >>> s);
        z_d = z_in - atan;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[s] <= x_d;
        y_q[s] <= y_d;
        z_q[s] <= z_d;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (en_i) begin
        valid_q[s] <= (s == 0) ? valid_i : valid_q[(s == 0) ? 0 : s-1];
      end
    end
  end

  assign valid_o = valid_q[N-1];
  assign z_o     = z_q[N-1];

endmodule

/* sv/haversine_great_circle_distance_unit.sv */
// throughput: one coordinate pair per cycle; a stalled result freezes the whole pipeline
// the depth is set by the 32-step rotation cordic, the 31-step root and the 32-step
// vectoring cordic, one step per stage
// reset clears all valid bits and loads the sphere radius with 6371 km
module haversine_great_circle_distance_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [31:0]                 first_latitude_i,
  input  logic signed [32:0]                 first_longitude_i,
  input  logic signed [31:0]                 second_latitude_i,
  input  logic signed [32:0]                 second_longitude_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [hgcd_pkg::DIST_W-1:0]        distance_q16_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [hgcd_pkg::RADIUS_W-1:0]      sphere_radius_q8_i
);

  localparam int AW = hgcd_pkg::ANGLE_W;

  logic en;
  logic [hgcd_pkg::RADIUS_W-1:0] radius_q;

  logic                 in_v_q;
  logic signed [AW-1:0] ang_q [hgcd_pkg::LANES];

  logic                               prep_v;
  logic signed [hgcd_pkg::TRIG_W-1:0] prep_z [hgcd_pkg::LANES];
  logic [hgcd_pkg::LANES-1:0]         prep_flip;
  logic                               rot_v;
  logic signed [hgcd_pkg::TRIG_W-1:0] trig [hgcd_pkg::LANES];
  logic                               hav_v;
  logic [hgcd_pkg::A_W-1:0]           hav_a;
  logic                               sq_v;
  logic [hgcd_pkg::ROOT_W-1:0]        root_a, root_b;
  logic                               vec_v;
  logic signed [hgcd_pkg::VZ_W-1:0]   vec_z;

  logic signed [hgcd_pkg::VZ_W:0] c_wide;
  logic [hgcd_pkg::C_W-1:0]       c_clamp;
  logic                           mul_v_q;
  logic [55:0]                    prod_q;
  logic [56:0]                    prod_rnd;
  logic                           out_v_q;
  logic [hgcd_pkg::DIST_W-1:0]    dist_q;

  // whole pipeline moves unless a result waits on a stalled output
  assign en         = !(out_v_q && out_stall_i);
  assign in_stall_o = !en;

  // radius register, always ready for a transfer
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= hgcd_pkg::RADIUS_RESET_Q8;
    end else if (cfg_valid_i && cfg_ready_o) begin
      radius_q <= sphere_radius_q8_i;
    end
  end

  // half differences and doubled latitudes, all as degrees q25
  always_ff @(posedge clk_i) begin
    if (en) begin
      ang_q[0] <= AW'(second_latitude_i) - AW'(first_latitude_i);
      ang_q[1] <= AW'(second_longitude_i) - AW'(first_longitude_i);
      ang_q[2] <= $signed({first_latitude_i[31], first_latitude_i, 1'b0});
      ang_q[3] <= $signed({second_latitude_i[31], second_latitude_i, 1'b0});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (en) begin
      in_v_q <= in_valid_i;
    end
  end

  hgcd_angle_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_v_q),
    .angle_i (ang_q),
    .valid_o (prep_v),
    .z_o     (prep_z),
    .flip_o  (prep_flip)
  );

  hgcd_cordic_rot u_rot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (prep_v),
    .z_i     (prep_z),
    .flip_i  (prep_flip),
    .valid_o (rot_v),
    .trig_o  (trig)
  );

  hgcd_haver u_haver (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (rot_v),
    .trig_i  (trig),
    .valid_o (hav_v),
    .a_o     (hav_a)
  );

  hgcd_isqrt u_sqrt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (hav_v),
    .a_i      (hav_a),
    .valid_o  (sq_v),
    .root_a_o (root_a),
    .root_b_o (root_b)
  );

  hgcd_cordic_vec u_vec (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_v),
    .x_i     (root_b),
    .y_i     (root_a),
    .valid_o (vec_v),
    .z_o     (vec_z)
  );

  // central angle, clamped to zero..pi
  always_comb begin
    c_wide = $signed({vec_z, 1'b0});
    if (c_wide[hgcd_pkg::VZ_W]) begin
      c_clamp = '0;
    end else if (c_wide > $signed((hgcd_pkg::VZ_W+1)'(hgcd_pkg::PI_Q30))) begin
      c_clamp = hgcd_pkg::PI_Q30;
    end else begin
      c_clamp = c_wide[hgcd_pkg::C_W-1:0];
    end
  end

  // scale by radius, then round to q16
  assign prod_rnd = 57'(prod_q) + 57'(64'd2097152);

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q <= 56'(radius_q) * 56'(c_clamp);
      dist_q <= prod_rnd[22 +: hgcd_pkg::DIST_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      mul_v_q <= vec_v;
      out_v_q <= mul_v_q;
    end
  end

  assign out_valid_o    = out_v_q;
  assign distance_q16_o = dist_q;

  // a delivered distance never exceeds half the largest circumference
  a_dist_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> distance_q16_o <= hgcd_pkg::DIST_MAX_Q16)
    else $error("distance beyond half circumference");

  // vectoring of two non-negative roots lands in the first quadrant
  a_vec_quadrant : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vec_v |-> (vec_z >= -$signed(37'sd1024)) &&
              (vec_z <= $signed(hgcd_pkg::HALF_PI_Q30 + 36'd1024)))
    else $error("vectoring angle outside first quadrant");

  // a frozen pipeline keeps the same result on the output
  a_hold_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(distance_q16_o)))
    else $error("stalled result changed");

endmodule

/* tb/haversine_great_circle_distance_checker.sv */
module haversine_great_circle_distance_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic signed [31:0]            first_latitude_i,
  input  logic signed [32:0]            first_longitude_i,
  input  logic signed [31:0]            second_latitude_i,
  input  logic signed [32:0]            second_longitude_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [hgcd_pkg::DIST_W-1:0]   distance_q16_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [hgcd_pkg::RADIUS_W-1:0] sphere_radius_q8_i,
  output int                            accepted_o,
  output int                            delivered_o,
  output int                            fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint FULL_TURN    = longint'(360) << 25;
  localparam longint HALF_TURN    = longint'(180) << 25;
  localparam longint QUARTER_TURN = longint'(90) << 25;
  localparam longint ONE          = longint'(1) << 30;
  localparam longint PI_LIMIT     = 64'd3373259426;

  logic [hgcd_pkg::RADIUS_W-1:0] radius_q8;
  logic [hgcd_pkg::DIST_W-1:0]   expected_distances [$];

  // one mismatch line, counted
  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    fail_count_o++;
  endtask

  // rotation cordic on an angle in q25 degrees, sin and cos in q30
  function automatic void sin_cos_q30(input longint deg_q25, output longint s,
                                      output longint c);
    longint r, z, x, y, nx, mag;
    bit flip;
    r = deg_q25 % FULL_TURN;
    flip = 0;
    if (r < 0) r += FULL_TURN;
    if (r >= HALF_TURN) r -= FULL_TURN;
    if (r > QUARTER_TURN) begin
      r = HALF_TURN - r;
      flip = 1;
    end else if (r < -QUARTER_TURN) begin
      r = -HALF_TURN - r;
      flip = 1;
    end
    mag = (r < 0) ? -r : r;
    z = (mag * 74961321 + (longint'(1) << 26)) >>> 27;
    if (r < 0) z = -z;
    x = 652032874;
    y = 0;
    for (int i = 0; i < hgcd_pkg::CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= longint'(hgcd_pkg::ATAN_Q30[i]);
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += longint'(hgcd_pkg::ATAN_Q30[i]);
      end
      x = nx;
    end
    s = y;
    c = flip ? -x : x;
  endfunction

  function automatic longint mul_round_q30(input longint a, input longint b);
    return (a * b + (longint'(1) << 29)) >>> 30;
  endfunction

  function automatic longint floor_root(input longint unsigned v);
    longint unsigned res, bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w >>= 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v -= res + bit_w;
        res = (res >> 1) + bit_w;
      end else begin
        res >>= 1;
      end
      bit_w >>= 2;
    end
    return longint'(res);
  endfunction

  // vectoring cordic, angle of (x, y) in q30 radians
  function automatic longint arc_q30(input longint x, input longint y);
    longint z, nx;
    z = 0;
    for (int i = 0; i < hgcd_pkg::CORDIC_STEPS; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += longint'(hgcd_pkg::ATAN_Q30[i]);
      end else begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= longint'(hgcd_pkg::ATAN_Q30[i]);
      end
      x = nx;
    end
    return z;
  endfunction

  function automatic logic [hgcd_pkg::DIST_W-1:0] great_circle_q16(
    input longint lat1, input longint lon1, input longint lat2, input longint lon2,
    input logic [hgcd_pkg::RADIUS_W-1:0] radius);
    longint s_lat, s_lon, c1, c2, unused, a, c, root_a, root_b;
    longint unsigned scaled;
    sin_cos_q30(lat2 - lat1, s_lat, unused);
    sin_cos_q30(lon2 - lon1, s_lon, unused);
    sin_cos_q30(lat1 * 2, unused, c1);
    sin_cos_q30(lat2 * 2, unused, c2);
    a = mul_round_q30(s_lat, s_lat)
        + mul_round_q30(mul_round_q30(c1, c2), mul_round_q30(s_lon, s_lon));
    if (a < 0) a = 0;
    if (a > ONE) a = ONE;
    root_a = floor_root(longint'(a) << 30);
    root_b = floor_root(longint'(ONE - a) << 30);
    c = 2 * arc_q30(root_b, root_a);
    if (c < 0) c = 0;
    if (c > PI_LIMIT) c = PI_LIMIT;
    scaled = (longint'(radius) * c + (longint'(1) << 21)) >> 21 >> 1;
    return scaled[hgcd_pkg::DIST_W-1:0];
  endfunction

  // watch all three channels
  always @(posedge clk_i or negedge rst_ni) begin
    logic [hgcd_pkg::DIST_W-1:0] want;
    if (!rst_ni) begin
      radius_q8 <= hgcd_pkg::RADIUS_RESET_Q8;
      expected_distances.delete();
      accepted_o = 0;
      delivered_o = 0;
      fail_count_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        expected_distances.push_back(great_circle_q16(first_latitude_i, first_longitude_i,
                                                      second_latitude_i, second_longitude_i,
                                                      radius_q8));
        accepted_o++;
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_distances.size() == 0) begin
          report_mismatch($sformatf("unexpected distance %0d", distance_q16_i));
        end else begin
          want = expected_distances.pop_front();
          if (distance_q16_i !== want)
            report_mismatch($sformatf("distance_q16 got %0d want %0d", distance_q16_i, want));
          delivered_o++;
        end
      end
      if (cfg_valid_i && cfg_ready_i) radius_q8 <= sphere_radius_q8_i;
    end
  end

endmodule

/* tb/haversine_great_circle_distance_unit_test.sv */
module haversine_great_circle_distance_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint LAT_MAX   = 1509949440;
  localparam longint LON_MAX   = 64'd3019898880;
  localparam int     CYCLE_CAP = 1000000;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic signed [31:0] lat1 = '0;
  logic signed [32:0] lon1 = '0;
  logic signed [31:0] lat2 = '0;
  logic signed [32:0] lon2 = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [hgcd_pkg::DIST_W-1:0] distance_q16;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [hgcd_pkg::RADIUS_W-1:0] radius_q8 = hgcd_pkg::RADIUS_RESET_Q8;

  int accepted, delivered, fail_count, cycles, stall_left;
  bit sender_gaps, sink_gaps;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  haversine_great_circle_distance_unit dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .first_latitude_i(lat1), .first_longitude_i(lon1),
    .second_latitude_i(lat2), .second_longitude_i(lon2),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .distance_q16_o(distance_q16),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .sphere_radius_q8_i(radius_q8)
  );

  haversine_great_circle_distance_checker distance_check (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .first_latitude_i(lat1), .first_longitude_i(lon1),
    .second_latitude_i(lat2), .second_longitude_i(lon2),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .distance_q16_i(distance_q16),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready), .sphere_radius_q8_i(radius_q8),
    .accepted_o(accepted), .delivered_o(delivered), .fail_count_o(fail_count)
  );

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  // result side stall, drawn per transfer
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 0;
      if (sink_gaps && out_valid && !out_stall) stall_left <= $urandom_range(0, 19);
    end
  end

  // one coordinate transfer, called at a rising edge
  task automatic send_pair(input longint a_lat, input longint a_lon,
                           input longint b_lat, input longint b_lon);
    int gap;
    gap = sender_gaps ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    lat1 <= a_lat[31:0];
    lon1 <= a_lon[32:0];
    lat2 <= b_lat[31:0];
    lon2 <= b_lon[32:0];
    do @(negedge clk); while (in_stall);
    @(posedge clk);
  endtask

  // wait for the pipeline to drain
  task automatic drain();
    in_valid <= 0;
    while (delivered != accepted) @(posedge clk);
    repeat (130) @(posedge clk);
  endtask

  task automatic write_radius(input logic [hgcd_pkg::RADIUS_W-1:0] value);
    cfg_valid <= 1;
    radius_q8 <= value;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 0;
  endtask

  function automatic longint pick_lat(input bit full_width);
    longint unsigned r;
    if (full_width) return longint'($signed($urandom));
    r = {$urandom, $urandom};
    return longint'(r % (2 * LAT_MAX + 1)) - LAT_MAX;
  endfunction

  function automatic longint pick_lon(input bit full_width);
    longint unsigned r;
    logic signed [32:0] w;
    if (full_width) begin
      w = {1'($urandom_range(0, 1)), 32'($urandom)};
      return longint'(w);
    end
    r = {$urandom, $urandom};
    return longint'(r % (2 * LON_MAX + 1)) - LON_MAX;
  endfunction

  // mostly real coordinates, some close neighbours, a few raw bit patterns
  task automatic random_pair();
    longint a_lat, a_lon, b_lat, b_lon;
    int kind;
    kind = $urandom_range(0, 9);
    a_lat = pick_lat(kind == 0);
    a_lon = pick_lon(kind == 0);
    if (kind < 7) begin
      b_lat = pick_lat(kind == 0);
      b_lon = pick_lon(kind == 0);
    end else begin
      b_lat = a_lat + $signed($urandom_range(0, 2000000)) - 1000000;
      b_lon = a_lon + $signed($urandom_range(0, 2000000)) - 1000000;
    end
    send_pair(a_lat, a_lon, b_lat, b_lon);
  endtask

  initial begin
    logic [hgcd_pkg::RADIUS_W-1:0] radii [6];
    radii = '{24'd1630976, 24'd1, 24'hFFFFFF, 24'd0, 24'd256, 24'd1630976};
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: same point, antipodes, poles, field extremes
    sender_gaps = 0;
    sink_gaps = 0;
    send_pair(0, 0, 0, 0);
    send_pair(LAT_MAX / 2, LON_MAX / 3, LAT_MAX / 2, LON_MAX / 3);
    send_pair(0, 0, 0, LON_MAX);
    send_pair(0, -LON_MAX, 0, LON_MAX);
    send_pair(LAT_MAX, 0, -LAT_MAX, 0);
    send_pair(LAT_MAX, 0, LAT_MAX, LON_MAX);
    send_pair(-LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX);
    send_pair(0, 0, 1, 0);
    send_pair(0, 0, 0, 1);
    send_pair(-2147483648, -64'sd4294967296, 2147483647, 64'sd4294967295);
    send_pair(2147483647, 64'sd4294967295, -2147483648, -64'sd4294967296);
    send_pair(-1, -1, -1, -1);
    send_pair(LAT_MAX + 1, LON_MAX + 1, -LAT_MAX - 1, -LON_MAX - 1);
    send_pair(LAT_MAX / 3, 0, LAT_MAX / 3 + 10, 10);
    sender_gaps = 1;
    sink_gaps = 1;
    repeat (8) random_pair();

    // random phases, one radius setting each, written while drained
    for (int p = 0; p < 6; p++) begin
      drain();
      write_radius(p == 5 ? 24'($urandom_range(1, 24'hFFFFFF)) : radii[p]);
      sender_gaps = (p % 3) != 1;
      sink_gaps = (p % 3) != 2;
      for (int n = 0; n < 240; n++) begin
        if (n == 120) drain();
        random_pair();
      end
    end

    drain();
    $display("covered %0d coordinate pairs over six sphere radii incl zero and full scale,",
             accepted);
    $display("with sender gaps and result stalls in mixed phases and raw bit patterns");
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* files.f */
sv/hgcd_pkg.sv
sv/hgcd_angle_prep.sv
sv/hgcd_cordic_rot.sv
sv/hgcd_haver.sv
sv/hgcd_isqrt.sv
sv/hgcd_cordic_vec.sv
sv/haversine_great_circle_distance_unit.sv
tb/haversine_great_circle_distance_checker.sv
tb/haversine_great_circle_distance_unit_test.sv
